// ===== sv/dlrm_pkg.sv =====
// Shared types and constants for the dense layer MAC block.
package dlrm_pkg;

  localparam int MAX_INPUTS  = 16;
  localparam int MAX_OUTPUTS = 16;
  localparam int DATA_W = 16;
  localparam int FRAC_BITS = 8;
  localparam int CFG_W = 5;
  localparam int CFG_IDX_W = 2;

  // Input actions
  typedef enum logic [1:0] {
    ACT_WEIGHT = 2'd0,
    ACT_BIAS   = 2'd1,
    ACT_INPUT  = 2'd2,
    ACT_RUN    = 2'd3
  } action_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INPUTS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACT     = 2'd2;

  typedef struct packed {
    logic [1:0]              action;
    logic [7:0]              index;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]              out_index;
    logic signed [DATA_W-1:0] out_value;
    logic                    last;
  } out_item_t;

endpackage

// ===== sv/dense_layer_relu_mac.sv =====
// Top level of the fully connected layer with optional ReLU.
// Usage:
//  - in_ channel (valid/ready) takes transactions that write a weight,
//    a bias, an input element, or run the layer.
//  - Store writes pass through the front end's S_IDLE and S_OUT states; a weight
//    write also divides index by inputs_in_use in S_DIV, one subtraction per cycle.
//  - A run emits outputs_in_use results on the out_ channel in neuron
//    order, last marking the final one. Each result is built by one
//    multiply-accumulate per cycle over the row's inputs_in_use weights
//    and inputs.
//  - A two-entry queue sits between front and back ends so up to two writes
//    can wait in the queue while a run is busy.
//  - A stalled receiver holds the result register; the back end waits.
//  - Synchronous reset clears the controls, registers to their defaults,
//    and the weight and bias valid bits, so all weights and biases read 0.
//  - cfg_ writes take effect at once; the user, not the block, keeps them to idle.
module dense_layer_relu_mac
  import dlrm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CMD_W = 2 + 1 + 8 + 8 + 16;

  logic [4:0] ni_cfg_r, no_cfg_r;
  logic       act_r;
  logic [4:0] ni, no;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ni_cfg_r <= 5'd16;
      no_cfg_r <= 5'd16;
      act_r <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == REG_INPUTS) ni_cfg_r <= cfg_data;
      if (cfg_index == REG_OUTPUTS) no_cfg_r <= cfg_data;
      if (cfg_index == REG_ACT) act_r <= cfg_data[0];
    end
  end

  // Effective sizes clamped to 1..max
  assign ni = (ni_cfg_r == 5'd0) ? 5'd1 :
              (32'(ni_cfg_r) > MAX_INPUTS) ? 5'(MAX_INPUTS) : ni_cfg_r;
  assign no = (no_cfg_r == 5'd0) ? 5'd1 :
              (32'(no_cfg_r) > MAX_OUTPUTS) ? 5'(MAX_OUTPUTS) : no_cfg_r;

  logic f_valid, f_ready, f_write, b_valid, b_ready, b_write;
  logic [1:0] f_act, b_act;
  logic [7:0] f_row, f_col, b_row, b_col;
  logic signed [15:0] f_val, b_val;
  logic [CMD_W-1:0] q_out;

  dlrm_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .ni, .no,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_action(f_act),
    .cmd_write(f_write), .cmd_row(f_row), .cmd_col(f_col), .cmd_value(f_val)
  );

  dlrm_queue #(.W(CMD_W)) u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_data({f_act, f_write, f_row, f_col, f_val}),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(q_out)
  );

  assign {b_act, b_write, b_row, b_col, b_val} = q_out;

  dlrm_back u_back (
    .clk, .rst_n, .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd_action(b_act),
    .cmd_write(b_write), .cmd_row(b_row), .cmd_col(b_col), .cmd_value(b_val),
    .ni, .no, .act(act_r), .out_valid, .out_ready, .out_data
  );

  // A held result must not change while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // ReLU results are never negative
  a_relu: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && act_r |-> !out_data.out_value[15])
    else $error("negative ReLU output");

  // Results stay within the neurons in use
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (5'(out_data.out_index) < no))
    else $error("output index out of range");

endmodule

// ===== sv/dlrm_front.sv =====
// Front end: accepts items, decodes store addresses and run requests.
module dlrm_front
  import dlrm_pkg::*;
#(
  parameter int NI_W = 5,
  parameter int NO_W = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  input  logic [NI_W-1:0] ni,
  input  logic [NO_W-1:0] no,
  // decoded command to queue
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output logic [1:0]      cmd_action,
  output logic            cmd_write,
  output logic [7:0]      cmd_row,
  output logic [7:0]      cmd_col,
  output logic signed [15:0] cmd_value
);

  // Divider state: index / ni by repeated subtraction, one step per cycle
  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} st_t;
  st_t st_r;
  in_item_t item_r;
  logic [7:0] rem_r, quo_r;
  logic [8:0] rem_ext;

  assign rem_ext = {1'b0, rem_r};
  assign in_ready = (st_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: if (in_valid) begin
          item_r <= in_data;
          rem_r  <= in_data.index;
          quo_r  <= '0;
          st_r   <= (in_data.action == ACT_WEIGHT) ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (rem_ext >= 9'(ni)) begin
            rem_r <= rem_r - 8'(ni);
            quo_r <= quo_r + 8'd1;
          end else begin
            st_r <= S_OUT;
          end
        end
        S_OUT: if (cmd_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // Classify the item and range check its index
  always_comb begin
    cmd_valid  = (st_r == S_OUT);
    cmd_action = item_r.action;
    cmd_value  = item_r.value;
    cmd_row    = '0;
    cmd_col    = '0;
    cmd_write  = 1'b0;
    case (item_r.action)
      ACT_WEIGHT: begin
        cmd_col   = rem_r;
        cmd_row   = (no == NO_W'(1)) ? 8'd0 : quo_r;
        cmd_write = ({1'b0, cmd_row} < 9'(no));
      end
      ACT_BIAS: begin
        cmd_row   = item_r.index;
        cmd_write = ({1'b0, item_r.index} < 9'(no));
      end
      ACT_INPUT: begin
        cmd_col   = item_r.index;
        cmd_write = ({1'b0, item_r.index} < 9'(ni));
      end
      default: cmd_write = 1'b0;
    endcase
  end

endmodule

// ===== sv/dlrm_queue.sv =====
// Two-entry queue between front and back ends.
module dlrm_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== sv/dlrm_back.sv =====
// Back end: holds the stores and runs the multiply-accumulate walk.
module dlrm_back
  import dlrm_pkg::*;
#(
  parameter int NI_W = 5,
  parameter int NO_W = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  logic [1:0]      cmd_action,
  input  logic            cmd_write,
  input  logic [7:0]      cmd_row,
  input  logic [7:0]      cmd_col,
  input  logic signed [15:0] cmd_value,
  input  logic [NI_W-1:0] ni,
  input  logic [NO_W-1:0] no,
  input  logic            act,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data
);

  localparam int RW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int CW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int WDEPTH = MAX_OUTPUTS * MAX_INPUTS;
  localparam int AW = RW + CW;
  localparam int ACC_W = 32 + CW + 2;

  // Weight memory with one valid bit per row-column entry
  logic signed [15:0] wmem [WDEPTH];
  logic [WDEPTH-1:0]  wvalid_r;
  logic signed [15:0] bias_r [MAX_OUTPUTS];
  logic [MAX_OUTPUTS-1:0] bvalid_r;
  logic signed [15:0] imem [MAX_INPUTS];

  typedef enum logic [2:0] {B_IDLE, B_RD, B_MAC, B_FIN, B_EMIT} bst_t;
  bst_t st_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic [CW:0]   rd_cnt_r;
  logic          p_v_r, m_v_r;
  logic signed [15:0] wq_r, iq_r;
  logic          wqv_r;
  logic signed [31:0] prod_r;
  logic signed [ACC_W-1:0] acc_r, acc_fin;
  logic signed [ACC_W-9:0] shifted;
  logic signed [15:0] sat;
  logic [AW-1:0] waddr, raddr;
  logic cmd_fire;

  assign cmd_ready = (st_r == B_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign waddr = {cmd_row[RW-1:0], cmd_col[CW-1:0]};
  assign raddr = {row_r, col_r};

  // Store writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd_fire && cmd_write && cmd_action == ACT_WEIGHT) wmem[waddr] <= cmd_value;
    if (cmd_fire && cmd_write && cmd_action == ACT_INPUT) imem[cmd_col[CW-1:0]] <= cmd_value;
    if (cmd_fire && cmd_write && cmd_action == ACT_BIAS) bias_r[cmd_row[RW-1:0]] <= cmd_value;
    wq_r  <= wmem[raddr];
    wqv_r <= wvalid_r[raddr];
    iq_r  <= imem[col_r];
    prod_r <= (wqv_r ? wq_r : 16'sd0) * iq_r;
  end

  // Final bias and ReLU (both only when act is set), floor shift and saturation
  always_comb begin
    acc_fin = acc_r;
    if (act) begin
      acc_fin = acc_r + (ACC_W'(bvalid_r[row_r] ? bias_r[row_r] : 16'sd0) <<< FRAC_BITS);
      if (acc_fin < 0) acc_fin = '0;
    end
    shifted = acc_fin[ACC_W-1:FRAC_BITS];
    if (shifted > 32767) sat = 16'sh7fff;
    else if (shifted < -32768) sat = -16'sh8000;
    else sat = shifted[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      wvalid_r <= '0;
      bvalid_r <= '0;
      out_valid <= 1'b0;
      p_v_r <= 1'b0;
      m_v_r <= 1'b0;
    end else begin
      // read data valid, then product valid
      p_v_r <= (st_r == B_RD);
      m_v_r <= p_v_r;
      // accumulate, or clear at the start of each neuron
      if (m_v_r) acc_r <= acc_r + ACC_W'(prod_r);
      else if (st_r == B_EMIT || (st_r == B_IDLE && cmd_valid && cmd_action == ACT_RUN))
        acc_r <= '0;
      // result register
      if (st_r == B_FIN && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (st_r)
        B_IDLE: if (cmd_valid) begin
          if (cmd_write && cmd_action == ACT_WEIGHT) wvalid_r[waddr] <= 1'b1;
          if (cmd_write && cmd_action == ACT_BIAS) bvalid_r[cmd_row[RW-1:0]] <= 1'b1;
          if (cmd_action == ACT_RUN) begin
            row_r <= '0;
            col_r <= '0;
            rd_cnt_r <= '0;
            st_r <= B_RD;
          end
        end
        B_RD: begin
          // issue one read per cycle for the row
          if (rd_cnt_r + 1'b1 == (CW+1)'(ni)) st_r <= B_MAC;
          else col_r <= col_r + 1'b1;
          rd_cnt_r <= rd_cnt_r + 1'b1;
        end
        B_MAC: if (!p_v_r && !m_v_r) st_r <= B_FIN;
        B_FIN: if (!out_valid || out_ready) begin
          out_data.out_index <= 4'(row_r);
          out_data.out_value <= sat;
          out_data.last <= (32'(row_r) + 1 == 32'(no));
          if (32'(row_r) + 1 == 32'(no)) st_r <= B_IDLE;
          else begin
            st_r <= B_EMIT;
          end
        end
        B_EMIT: begin
          row_r <= row_r + 1'b1;
          col_r <= '0;
          rd_cnt_r <= '0;
          st_r <= B_RD;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

endmodule
